// ----- rtl/core/mfep_pkg.sv -----
// Package for the MIDI file event parser: result record, event codes, tone table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mfep_pkg;

    localparam logic [3:0] EV_HEADER    = 4'd0;
    localparam logic [3:0] EV_TRK_START = 4'd1;
    localparam logic [3:0] EV_WAIT      = 4'd2;
    localparam logic [3:0] EV_META      = 4'd3;
    localparam logic [3:0] EV_TEMPO     = 4'd4;
    localparam logic [3:0] EV_NOTE_ON   = 4'd5;
    localparam logic [3:0] EV_NOTE_OFF  = 4'd6;
    localparam logic [3:0] EV_TRK_END   = 4'd7;
    localparam logic [3:0] EV_BAD_HDR   = 4'd8;
    localparam logic [3:0] EV_UNK_META  = 4'd9;
    localparam logic [3:0] EV_UNK_STAT  = 4'd10;
    localparam logic [3:0] EV_UNK_CHUNK = 4'd11;
    localparam logic [3:0] EV_TRUNC     = 4'd12;

    // One result record as it leaves the block.
    typedef struct packed {
        logic [3:0]  kind;
        logic [51:0] main_value;
        logic [15:0] aux_value;
        logic [15:0] tpq;
        logic [3:0]  channel;
        logic [6:0]  note;
        logic [6:0]  velocity;
        logic [13:0] tone;
        logic        last;
    } t_result;

    function automatic logic [8:0] tone_base(input logic [3:0] idx);
        logic [8:0] v;
        begin
            case (idx)
                4'd0: v = 9'd262;
                4'd1: v = 9'd277;
                4'd2: v = 9'd294;
                4'd3: v = 9'd311;
                4'd4: v = 9'd330;
                4'd5: v = 9'd349;
                4'd6: v = 9'd370;
                4'd7: v = 9'd392;
                4'd8: v = 9'd415;
                4'd9: v = 9'd440;
                4'd10: v = 9'd466;
                4'd11: v = 9'd494;
                default: v = 9'd0;
            endcase
            return v;
        end
    endfunction

    function automatic logic meta_known(input logic [7:0] t);
        return (t <= 8'h09) || (t == 8'h20) || (t == 8'h21) || (t == 8'h2F) ||
               (t == 8'h51) || (t == 8'h54) || (t == 8'h58) || (t == 8'h59) ||
               (t == 8'h7F);
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/mfep_queue.sv -----
// Two-entry result queue between the parser front end and the output port.
// Depends on mfep_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mfep_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  mfep_pkg::t_result    i_data,
    output logic                 o_empty,
    output logic [1:0]           o_count,
    input  wire                  i_pop,
    output mfep_pkg::t_result    o_data
);
    mfep_pkg::t_result r_mem [2];
    logic r_wp;
    logic r_rp;
    logic [1:0] r_cnt;

    assign o_empty = (r_cnt == 2'd0);
    assign o_count = r_cnt;
    assign o_data  = r_mem[r_rp];

    // Pointers and fill count; the front end only pushes when there is room.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> (!i_push || i_pop)) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> !i_pop) else $error("queue underflow");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
endmodule
`default_nettype wire

// ----- rtl/core/mfep_divider.sv -----
// Radix-2 restoring divider for tempo / division (24 by 16 bits).
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module mfep_divider (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire  [23:0] i_num,
    input  wire  [15:0] i_den,
    output logic        o_busy,
    output logic [23:0] o_quot
);
    logic [23:0] r_q;
    logic [16:0] r_rem;
    logic [15:0] r_den;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [16:0] w_trial;
    logic [17:0] w_diff;

    assign o_busy = r_busy;
    assign o_quot = r_q;
    assign w_trial = {r_rem[15:0], r_q[23]};
    assign w_diff = {1'b0, w_trial} - {2'b00, r_den};

    // One quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 5'd0;
            r_q    <= 24'd1041;
            r_rem  <= 17'd0;
            r_den  <= 16'd1;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 5'd0;
            r_q    <= i_num;
            r_rem  <= 17'd0;
            r_den  <= i_den;
        end else if (r_busy) begin
            if (!w_diff[17]) begin
                r_rem <= w_diff[16:0];
                r_q   <= {r_q[22:0], 1'b1};
            end else begin
                r_rem <= w_trial;
                r_q   <= {r_q[22:0], 1'b0};
            end
            r_cnt <= r_cnt + 5'd1;
            if (r_cnt == 5'd23) r_busy <= 1'b0;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/mfep_front.sv -----
// Parser front end: byte-level state machine that classifies bytes and emits results.
// Depends on mfep_pkg and mfep_divider.
`timescale 1ns / 1ps
`default_nettype none
module mfep_front (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_ready,
    input  wire  [7:0]         i_byte,
    input  wire                i_last,
    input  wire  [1:0]         i_q_count,
    output logic               o_push,
    output mfep_pkg::t_result  o_res
);
    typedef enum logic [4:0] {
        HMAGIC, HLEN, HFMT, HDIV, CMAGIC, CSIZE, DELTA, STATUS, NKEY, NVEL,
        SKIPD, MTYPE, MLEN, MDATA, SKIPTRK, STOP
    } t_phase;
    typedef enum logic [2:0] { S_IN, S_MUL, S_EMIT0, S_EMIT1 } t_step;

    t_phase r_ph, n_ph;
    t_step r_st;
    logic [2:0]  r_fbc, n_fbc;
    logic [31:0] r_fs, n_fs;
    logic [31:0] r_tbl, n_tbl;
    logic [15:0] r_tpq, n_tpq;
    logic [23:0] r_tempo, n_tempo;
    logic [27:0] r_va, n_va;
    logic [7:0]  r_stat, n_stat;
    logic [7:0]  r_mt, n_mt;
    logic [27:0] r_mbl, n_mbl;
    logic [6:0]  r_nh, n_nh;
    mfep_pkg::t_result r_res0, r_res1, n_res0, n_res1;
    logic [1:0]  r_n, n_n;
    logic        n_mulpend;
    logic        r_divgo, n_divgo;
    logic [23:0] r_divnum, n_divnum;
    logic [15:0] r_divden, n_divden;
    logic [51:0] w_prod;
    logic [27:0] r_delta, n_delta;
    logic        r_last, n_last;
    logic        w_div_busy;
    logic [23:0] w_upt;

    mfep_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_divgo),
        .i_num(r_divnum), .i_den(r_divden), .o_busy(w_div_busy), .o_quot(w_upt)
    );

    assign o_ready = (r_st == S_IN) && !r_divgo && !w_div_busy;

    function automatic mfep_pkg::t_result mk(input logic [3:0] k, input logic [51:0] m,
                                             input logic [15:0] a);
        mfep_pkg::t_result r;
        begin
            r = '0;
            r.kind = k;
            r.main_value = m;
            r.aux_value = a;
            return r;
        end
    endfunction

    // Octave and note within the octave come from parallel compares against octave bounds.
    function automatic logic [13:0] beep(input logic [6:0] nt);
        logic [3:0] oct;
        logic [6:0] base;
        logic [3:0] idx;
        logic [13:0] fq;
        begin
            oct = 4'd0;
            base = 7'd0;
            for (int k = 1; k <= 10; k++) begin
                if (nt >= 7'(12 * k)) begin
                    oct = 4'(k);
                    base = 7'(12 * k);
                end
            end
            idx = 4'(nt - base);
            fq = {5'd0, mfep_pkg::tone_base(idx)};
            if (nt > 7'd71) fq = 14'(fq << (oct - 4'd5));
            else if (nt < 7'd60) fq = fq >> (4'd5 - oct);
            return fq;
        end
    endfunction

    // Byte decode: mirrors one step of the file grammar.
    always_comb begin
        logic [27:0] va7;
        logic [2:0]  fbc1;
        logic        vdone;
        n_ph = r_ph; n_fbc = r_fbc; n_fs = r_fs; n_tbl = r_tbl; n_tpq = r_tpq;
        n_tempo = r_tempo; n_va = r_va; n_stat = r_stat; n_mt = r_mt; n_mbl = r_mbl;
        n_nh = r_nh; n_res0 = '0; n_res1 = '0; n_n = 2'd0; n_mulpend = 1'b0;
        n_divgo = 1'b0; n_divnum = r_divnum; n_divden = r_divden; n_delta = r_delta;
        n_last = i_last;
        va7 = {r_va[20:0], i_byte[6:0]};
        fbc1 = r_fbc + 3'd1;
        vdone = !i_byte[7] || (fbc1 >= 3'd4);
        case (r_ph)
            HMAGIC: begin
                if (i_byte != ((r_fbc[1:0] == 2'd0) ? 8'h4D : (r_fbc[1:0] == 2'd1) ? 8'h54 :
                               (r_fbc[1:0] == 2'd2) ? 8'h68 : 8'h64)) begin
                    n_res0 = mk(mfep_pkg::EV_BAD_HDR, '0, '0); n_n = 2'd1; n_ph = STOP;
                end else if (fbc1 >= 3'd4) begin
                    n_fbc = '0; n_ph = HLEN;
                end else n_fbc = fbc1;
            end
            HLEN: begin
                if (fbc1 >= 3'd4) begin n_fbc = '0; n_fs = '0; n_ph = HFMT; end
                else n_fbc = fbc1;
            end
            HFMT: begin
                n_fs = {r_fs[23:0], i_byte};
                if (fbc1 >= 3'd4) begin n_fbc = '0; n_va = '0; n_ph = HDIV; end
                else n_fbc = fbc1;
            end
            HDIV: begin
                n_va = {12'd0, r_va[7:0], i_byte};
                if (fbc1 >= 3'd2) begin
                    n_fbc = '0;
                    if ({r_va[7:0], i_byte} == 16'd0) begin
                        n_res0 = mk(mfep_pkg::EV_BAD_HDR, {36'd0, r_fs[31:16]}, r_fs[15:0]);
                        n_n = 2'd1; n_ph = STOP;
                    end else begin
                        n_tpq = {r_va[7:0], i_byte};
                        n_divgo = 1'b1; n_divnum = r_tempo; n_divden = {r_va[7:0], i_byte};
                        n_res0 = mk(mfep_pkg::EV_HEADER, {36'd0, r_fs[31:16]}, r_fs[15:0]);
                        n_res0.tpq = {r_va[7:0], i_byte};
                        n_n = 2'd1; n_ph = CMAGIC;
                    end
                end else n_fbc = fbc1;
            end
            CMAGIC: begin
                if (i_byte != ((r_fbc[1:0] == 2'd0) ? 8'h4D : (r_fbc[1:0] == 2'd1) ? 8'h54 :
                               (r_fbc[1:0] == 2'd2) ? 8'h72 : 8'h6B)) begin
                    n_res0 = mk(mfep_pkg::EV_UNK_CHUNK, '0, '0); n_n = 2'd1; n_ph = STOP;
                end else if (fbc1 >= 3'd4) begin
                    n_fbc = '0; n_tbl = '0; n_ph = CSIZE;
                end else n_fbc = fbc1;
            end
            CSIZE: begin
                n_tbl = {r_tbl[23:0], i_byte};
                if (fbc1 >= 3'd4) begin
                    n_fbc = '0;
                    n_res0 = mk(mfep_pkg::EV_TRK_START, {20'd0, r_tbl[23:0], i_byte}, '0);
                    n_n = 2'd1;
                    if ({r_tbl[23:0], i_byte} == 32'd0) begin
                        n_res1 = mk(mfep_pkg::EV_TRK_END, '0, '0); n_n = 2'd2; n_ph = CMAGIC;
                    end else begin
                        n_ph = DELTA; n_va = '0;
                    end
                end else n_fbc = fbc1;
            end
            STOP: ;
            default: begin
                if (r_tbl != 32'd0) n_tbl = r_tbl - 32'd1;
                case (r_ph)
                    DELTA: begin
                        n_va = va7; n_fbc = fbc1;
                        if (vdone) begin
                            // Wait result is filled after the multiply step.
                            n_res0 = mk(mfep_pkg::EV_WAIT, '0, '0); n_n = 2'd1;
                            n_mulpend = 1'b1; n_delta = va7;
                            n_ph = STATUS; n_fbc = '0;
                        end
                    end
                    STATUS: begin
                        n_stat = i_byte;
                        if (i_byte == 8'hFF) n_ph = MTYPE;
                        else if (i_byte[7:4] == 4'h8 || i_byte[7:4] == 4'h9) n_ph = NKEY;
                        else if (i_byte[7:4] == 4'hA || i_byte[7:4] == 4'hB ||
                                 i_byte[7:4] == 4'hE) begin
                            n_ph = SKIPD; n_fbc = 3'd2;
                        end else if (i_byte[7:4] == 4'hC || i_byte[7:4] == 4'hD) begin
                            n_ph = SKIPD; n_fbc = 3'd1;
                        end else begin
                            n_res0 = mk(mfep_pkg::EV_UNK_STAT, '0, {8'd0, i_byte});
                            n_n = 2'd1; n_ph = SKIPTRK;
                        end
                    end
                    NKEY: begin n_nh = i_byte[6:0]; n_ph = NVEL; end
                    NVEL: begin
                        n_res0 = mk(mfep_pkg::EV_NOTE_OFF, '0, '0);
                        n_res0.channel = r_stat[3:0];
                        n_res0.note = r_nh;
                        if (r_stat[7:4] == 4'h9 && i_byte != 8'd0) begin
                            n_res0.kind = mfep_pkg::EV_NOTE_ON;
                            n_res0.velocity = i_byte[6:0];
                            n_res0.tone = beep(r_nh);
                        end
                        n_n = 2'd1; n_ph = DELTA; n_va = '0; n_fbc = '0;
                    end
                    SKIPD: begin
                        if (r_fbc <= 3'd1) begin n_ph = DELTA; n_va = '0; n_fbc = '0; end
                        else n_fbc = r_fbc - 3'd1;
                    end
                    MTYPE: begin n_mt = i_byte; n_ph = MLEN; n_va = '0; n_fbc = '0; end
                    MLEN: begin
                        n_va = va7; n_fbc = fbc1;
                        if (vdone) begin
                            if (mfep_pkg::meta_known(r_mt)) begin
                                n_res0 = mk(mfep_pkg::EV_META, {24'd0, va7}, {8'd0, r_mt});
                                n_n = 2'd1; n_mbl = va7;
                                if (va7 == 28'd0) begin
                                    n_ph = DELTA; n_va = '0; n_fbc = '0;
                                end else begin
                                    n_ph = MDATA; n_fs = '0;
                                    n_fbc = (r_mt == 8'h51 && va7 >= 28'd3) ? 3'd0 : 3'd3;
                                end
                            end else begin
                                n_res0 = mk(mfep_pkg::EV_UNK_META, {24'd0, va7}, {8'd0, r_mt});
                                n_n = 2'd1; n_ph = SKIPTRK;
                            end
                        end
                    end
                    MDATA: begin
                        if (r_mbl != 28'd0) n_mbl = r_mbl - 28'd1;
                        if (r_fbc < 3'd3) begin
                            n_fs = {r_fs[23:0], i_byte};
                            n_fbc = fbc1;
                            if (fbc1 == 3'd3) begin
                                n_tempo = {r_fs[15:0], i_byte};
                                if (r_tpq != 16'd0) begin
                                    n_divgo = 1'b1; n_divnum = {r_fs[15:0], i_byte};
                                    n_divden = r_tpq;
                                end
                                n_res0 = mk(mfep_pkg::EV_TEMPO, {28'd0, r_fs[15:0], i_byte},
                                            16'h0051);
                                n_n = 2'd1;
                            end
                        end
                        if (n_mbl == 28'd0) begin n_ph = DELTA; n_va = '0; n_fbc = '0; end
                    end
                    default: ;
                endcase
                if (n_tbl == 32'd0) begin
                    if (n_n == 2'd0) n_res0 = mk(mfep_pkg::EV_TRK_END, '0, '0);
                    else n_res1 = mk(mfep_pkg::EV_TRK_END, '0, '0);
                    n_n = n_n + 2'd1;
                    n_ph = CMAGIC; n_fbc = '0;
                end
            end
        endcase
        if (i_last) begin
            if (!(n_ph == STOP || (n_ph == CMAGIC && n_fbc == 3'd0))) begin
                if (n_n == 2'd0) n_res0 = mk(mfep_pkg::EV_TRUNC, '0, '0);
                else n_res1 = mk(mfep_pkg::EV_TRUNC, '0, '0);
                n_n = n_n + 2'd1;
            end
        end
    end

    // Queue writes: results leave one per cycle once the queue is empty enough.
    always_comb begin
        o_push = 1'b0;
        o_res = r_res0;
        o_res.last = (r_n == 2'd1);
        if (r_st == S_EMIT0 && r_n != 2'd0 && i_q_count == 2'd0) o_push = 1'b1;
        if (r_st == S_EMIT1) begin
            o_res = r_res1;
            o_res.last = 1'b1;
            o_push = (i_q_count != 2'd2);
        end
    end

    // State and sequencing: accept, optional multiply, then emit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IN; r_ph <= HMAGIC; r_fbc <= '0; r_fs <= '0; r_tbl <= '0;
            r_tpq <= 16'd480; r_tempo <= 24'd500000; r_va <= '0; r_stat <= '0;
            r_mt <= '0; r_mbl <= '0; r_nh <= '0; r_n <= '0;
            r_divgo <= 1'b0; r_last <= 1'b0;
        end else begin
            r_divgo <= 1'b0;
            case (r_st)
                S_IN: begin
                    if (i_valid && o_ready) begin
                        r_ph <= n_ph; r_fbc <= n_fbc; r_fs <= n_fs; r_tbl <= n_tbl;
                        r_tpq <= n_tpq; r_tempo <= n_tempo; r_va <= n_va; r_stat <= n_stat;
                        r_mt <= n_mt; r_mbl <= n_mbl; r_nh <= n_nh; r_n <= n_n;
                        r_divgo <= n_divgo; r_last <= n_last;
                        if (n_mulpend) r_st <= S_MUL;
                        else if (n_n != 2'd0) r_st <= S_EMIT0;
                        else if (n_last) r_st <= S_EMIT0;
                    end
                end
                S_MUL: r_st <= S_EMIT0;
                S_EMIT0: begin
                    if (r_n == 2'd0 || i_q_count == 2'd0) begin
                        if (r_n == 2'd2) r_st <= S_EMIT1;
                        else r_st <= S_IN;
                        if (r_last) begin
                            r_ph <= HMAGIC; r_fbc <= '0; r_fs <= '0; r_tbl <= '0;
                            r_tpq <= 16'd480; r_tempo <= 24'd500000; r_va <= '0;
                            r_stat <= '0; r_mt <= '0; r_mbl <= '0; r_nh <= '0;
                            r_divgo <= 1'b1;
                        end
                    end
                end
                S_EMIT1: if (i_q_count != 2'd2) r_st <= S_IN;
                default: r_st <= S_IN;
            endcase
        end
    end

    // Payload registers; the wait value is the registered product.
    always_ff @(posedge i_clk) begin
        if (r_st == S_IN && i_valid && o_ready) begin
            r_res0 <= n_res0; r_res1 <= n_res1; r_delta <= n_delta;
            if (n_divgo) begin r_divnum <= n_divnum; r_divden <= n_divden; end
        end
        if (r_st == S_EMIT0 && r_last) begin
            r_divnum <= 24'd500000; r_divden <= 16'd480;
        end
        if (r_st == S_MUL) r_res0.main_value <= w_prod;
    end
    assign w_prod = w_upt * r_delta;

    a_emit_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && r_st == S_EMIT0) |-> i_q_count == 2'd0) else $error("emit into busy queue");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_busy |-> !o_ready) else $error("accept during divide");
    a_mul_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_MUL) |=> (r_st == S_EMIT0)) else $error("multiply step lost");
endmodule
`default_nettype wire

// ----- rtl/core/midi_file_event_parser_top.sv -----
// Top level of the MIDI file event parser: front end, result queue, output port.
// Depends on mfep_pkg, mfep_front, mfep_queue.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
// Bytes of a Standard MIDI File enter on the input channel (i_valid/o_ready), with
// i_file_last high on the final byte. Each byte gives zero, one or two result
// requests on the output channel (o_valid/i_ready); o_last_of_run marks the last
// result of a byte. A byte with results passes through one emit step per result,
// and a wait result first passes a multiply step for the delta. The final byte
// always passes an emit step, even with no results.
// After the header division or a tempo meta, a radix-2 divider computes the
// microseconds per tick; input stalls from the divider start until the divide is
// done. The same happens after the final byte while the defaults are restored.
// Results pass through a two-entry queue; bytes without results keep flowing while
// the receiver holds off, but a byte with results waits until the queue is empty.
// Synchronous active-low reset returns the parser to awaiting the header with
// tempo 500000 and division 480, and empties the queue.
module midi_file_event_parser_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [7:0]  i_file_byte,
    input  wire         i_file_last,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [3:0]  o_event_kind,
    output logic [51:0] o_main_value,
    output logic [15:0] o_aux_value,
    output logic [15:0] o_ticks_per_quarter,
    output logic [3:0]  o_channel,
    output logic [6:0]  o_note_number,
    output logic [6:0]  o_velocity,
    output logic [13:0] o_tone_hz,
    output logic        o_last_of_run
);
    logic w_push;
    logic w_empty;
    logic [1:0] w_cnt;
    mfep_pkg::t_result w_in;
    mfep_pkg::t_result w_out;

    mfep_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_byte(i_file_byte), .i_last(i_file_last), .i_q_count(w_cnt),
        .o_push(w_push), .o_res(w_in)
    );

    mfep_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_data(w_in),
        .o_empty(w_empty), .o_count(w_cnt), .i_pop(o_valid && i_ready), .o_data(w_out)
    );

    // Output fields come straight from the queue head.
    assign o_valid             = !w_empty;
    assign o_event_kind        = w_out.kind;
    assign o_main_value        = w_out.main_value;
    assign o_aux_value         = w_out.aux_value;
    assign o_ticks_per_quarter = w_out.tpq;
    assign o_channel           = w_out.channel;
    assign o_note_number       = w_out.note;
    assign o_velocity          = w_out.velocity;
    assign o_tone_hz           = w_out.tone;
    assign o_last_of_run       = w_out.last;
endmodule
`default_nettype wire

// ----- test/mfep_event_checker.sv -----
// Checker for the MIDI file event parser: predicts the event records of each file byte
// and compares them with the output requests. Depends on mfep_pkg.
`timescale 1ns / 1ps
module mfep_event_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    input  wire         i_in_ready,
    input  wire  [7:0]  i_file_byte,
    input  wire         i_file_last,
    input  wire         i_out_valid,
    input  wire         i_ready,
    input  wire  [3:0]  i_event_kind,
    input  wire  [51:0] i_main_value,
    input  wire  [15:0] i_aux_value,
    input  wire  [15:0] i_ticks_per_quarter,
    input  wire  [3:0]  i_channel,
    input  wire  [6:0]  i_note_number,
    input  wire  [6:0]  i_velocity,
    input  wire  [13:0] i_tone_hz,
    input  wire         i_last_of_run,
    output int          o_errors,
    output int          o_pending
);

    localparam logic [31:0] HDR_TAG = 32'h4D546864;
    localparam logic [31:0] TRK_TAG = 32'h4D54726B;
    localparam logic [7:0]  META_STATUS = 8'hFF;
    localparam logic [7:0]  META_TEMPO = 8'h51;

    typedef enum logic [3:0] {
        PH_HMAGIC, PH_HLEN, PH_HFMT, PH_HDIV, PH_CMAGIC, PH_CSIZE, PH_DELTA,
        PH_STATUS, PH_NKEY, PH_NVEL, PH_SKIPD, PH_MTYPE, PH_MLEN, PH_MDATA,
        PH_SKIPTRK, PH_STOP
    } t_parse_ph;

    t_parse_ph   ph;
    logic [2:0]  cnt;
    logic [31:0] shreg;
    logic [31:0] trk_left;
    logic [15:0] tpq;
    logic [23:0] tempo;
    logic [23:0] us_tick;
    logic [27:0] vacc;
    logic [7:0]  status;
    logic [7:0]  mtype;
    logic [27:0] mleft;
    logic [6:0]  note_h;

    mfep_pkg::t_result run_events[$];
    mfep_pkg::t_result expected_events[$];

    task automatic clear_parser();
        ph = PH_HMAGIC;
        cnt = '0;
        shreg = '0;
        trk_left = '0;
        tpq = 16'd480;
        tempo = 24'd500000;
        us_tick = 24'd1041;
        vacc = '0;
        status = '0;
        mtype = '0;
        mleft = '0;
        note_h = '0;
    endtask

    // At most two records come from one byte; any further one is dropped.
    task automatic emit(input logic [3:0] kind, input logic [51:0] mainv,
                        input logic [15:0] aux, input logic [15:0] div,
                        input logic [3:0] ch, input logic [6:0] key,
                        input logic [6:0] vel, input logic [13:0] hz);
        mfep_pkg::t_result r;
        r = '{kind, mainv, aux, div, ch, key, vel, hz, 1'b0};
        if (run_events.size() < 2) run_events.push_back(r);
    endtask

    function automatic logic [13:0] beep_hz(input logic [6:0] key);
        logic [13:0] f;
        int oct;
        oct = key / 12;
        case (key % 12)
            0: f = 262;  1: f = 277;  2: f = 294;  3: f = 311;
            4: f = 330;  5: f = 349;  6: f = 370;  7: f = 392;
            8: f = 415;  9: f = 440;  10: f = 466; default: f = 494;
        endcase
        if (key > 71) f = f << (oct - 5);
        else if (key < 60) f = f >> (5 - oct);
        return f;
    endfunction

    function automatic logic meta_type_ok(input logic [7:0] t);
        return t <= 8'h09 || t == 8'h20 || t == 8'h21 || t == 8'h2F || t == 8'h51 ||
               t == 8'h54 || t == 8'h58 || t == 8'h59 || t == 8'h7F;
    endfunction

    function automatic logic varlen_done(input logic [7:0] b);
        vacc = {vacc[20:0], b[6:0]};
        cnt = cnt + 1'b1;
        return !b[7] || cnt >= 4;
    endfunction

    task automatic start_delta();
        ph = PH_DELTA;
        vacc = '0;
        cnt = '0;
    endtask

    // One byte inside a track body.
    task automatic track_step(input logic [7:0] b);
        logic [51:0] wait_us;
        if (trk_left != 0) trk_left = trk_left - 1;
        case (ph)
            PH_DELTA: begin
                if (varlen_done(b)) begin
                    wait_us = 52'(us_tick) * 52'(vacc);
                    emit(mfep_pkg::EV_WAIT, wait_us, 0, 0, 0, 0, 0, 0);
                    ph = PH_STATUS;
                    cnt = '0;
                end
            end
            PH_STATUS: begin
                status = b;
                if (b == META_STATUS) ph = PH_MTYPE;
                else if (b[7:4] == 4'h8 || b[7:4] == 4'h9) ph = PH_NKEY;
                else if (b[7:4] == 4'hA || b[7:4] == 4'hB || b[7:4] == 4'hE) begin
                    ph = PH_SKIPD;
                    cnt = 3'd2;
                end else if (b[7:4] == 4'hC || b[7:4] == 4'hD) begin
                    ph = PH_SKIPD;
                    cnt = 3'd1;
                end else begin
                    emit(mfep_pkg::EV_UNK_STAT, 0, {8'h00, b}, 0, 0, 0, 0, 0);
                    ph = PH_SKIPTRK;
                end
            end
            PH_NKEY: begin
                note_h = b[6:0];
                ph = PH_NVEL;
            end
            PH_NVEL: begin
                if (status[7:4] == 4'h9 && b != 0)
                    emit(mfep_pkg::EV_NOTE_ON, 0, 0, 0, status[3:0], note_h, b[6:0],
                         beep_hz(note_h));
                else
                    emit(mfep_pkg::EV_NOTE_OFF, 0, 0, 0, status[3:0], note_h, 0, 0);
                start_delta();
            end
            PH_SKIPD: begin
                if (cnt <= 1) start_delta();
                else cnt = cnt - 1'b1;
            end
            PH_MTYPE: begin
                mtype = b;
                ph = PH_MLEN;
                vacc = '0;
                cnt = '0;
            end
            PH_MLEN: begin
                if (varlen_done(b)) begin
                    if (meta_type_ok(mtype)) begin
                        emit(mfep_pkg::EV_META, 52'(vacc), {8'h00, mtype}, 0, 0, 0, 0, 0);
                        mleft = vacc;
                        if (vacc == 0) start_delta();
                        else begin
                            ph = PH_MDATA;
                            shreg = '0;
                            cnt = (mtype == META_TEMPO && vacc >= 3) ? 3'd0 : 3'd3;
                        end
                    end else begin
                        emit(mfep_pkg::EV_UNK_META, 52'(vacc), {8'h00, mtype}, 0, 0, 0, 0, 0);
                        ph = PH_SKIPTRK;
                    end
                end
            end
            PH_MDATA: begin
                if (mleft != 0) mleft = mleft - 1;
                if (cnt < 3) begin
                    shreg = {shreg[23:0], b};
                    cnt = cnt + 1'b1;
                    if (cnt == 3) begin
                        tempo = shreg[23:0];
                        if (tpq != 0) us_tick = tempo / tpq;
                        emit(mfep_pkg::EV_TEMPO, 52'(tempo), {8'h00, META_TEMPO}, 0, 0, 0, 0,
                             0);
                    end
                end
                if (mleft == 0) start_delta();
            end
            default: ;
        endcase
        if (trk_left == 0) begin
            emit(mfep_pkg::EV_TRK_END, 0, 0, 0, 0, 0, 0, 0);
            ph = PH_CMAGIC;
            cnt = '0;
        end
    endtask

    // Works out the records of one accepted byte and queues them.
    task automatic parse_byte(input logic [7:0] b, input logic last);
        mfep_pkg::t_result r;
        run_events.delete();
        case (ph)
            PH_HMAGIC: begin
                if (b != HDR_TAG[31 - 8 * cnt[1:0] -: 8]) begin
                    emit(mfep_pkg::EV_BAD_HDR, 0, 0, 0, 0, 0, 0, 0);
                    ph = PH_STOP;
                end else begin
                    cnt = cnt + 1'b1;
                    if (cnt >= 4) begin
                        cnt = '0;
                        ph = PH_HLEN;
                    end
                end
            end
            PH_HLEN: begin
                cnt = cnt + 1'b1;
                if (cnt >= 4) begin
                    cnt = '0;
                    shreg = '0;
                    ph = PH_HFMT;
                end
            end
            PH_HFMT: begin
                shreg = {shreg[23:0], b};
                cnt = cnt + 1'b1;
                if (cnt >= 4) begin
                    cnt = '0;
                    vacc = '0;
                    ph = PH_HDIV;
                end
            end
            PH_HDIV: begin
                vacc = {12'h000, vacc[7:0], b};
                cnt = cnt + 1'b1;
                if (cnt >= 2) begin
                    cnt = '0;
                    if (vacc[15:0] == 0) begin
                        emit(mfep_pkg::EV_BAD_HDR, 52'(shreg[31:16]), shreg[15:0], 0, 0, 0, 0,
                             0);
                        ph = PH_STOP;
                    end else begin
                        tpq = vacc[15:0];
                        us_tick = tempo / tpq;
                        emit(mfep_pkg::EV_HEADER, 52'(shreg[31:16]), shreg[15:0], tpq, 0, 0, 0,
                             0);
                        ph = PH_CMAGIC;
                    end
                end
            end
            PH_CMAGIC: begin
                if (b != TRK_TAG[31 - 8 * cnt[1:0] -: 8]) begin
                    emit(mfep_pkg::EV_UNK_CHUNK, 0, 0, 0, 0, 0, 0, 0);
                    ph = PH_STOP;
                end else begin
                    cnt = cnt + 1'b1;
                    if (cnt >= 4) begin
                        cnt = '0;
                        trk_left = '0;
                        ph = PH_CSIZE;
                    end
                end
            end
            PH_CSIZE: begin
                trk_left = {trk_left[23:0], b};
                cnt = cnt + 1'b1;
                if (cnt >= 4) begin
                    cnt = '0;
                    emit(mfep_pkg::EV_TRK_START, 52'(trk_left), 0, 0, 0, 0, 0, 0);
                    if (trk_left == 0) begin
                        emit(mfep_pkg::EV_TRK_END, 0, 0, 0, 0, 0, 0, 0);
                        ph = PH_CMAGIC;
                    end else begin
                        start_delta();
                    end
                end
            end
            PH_STOP: ;
            default: track_step(b);
        endcase
        if (last) begin
            if (!(ph == PH_STOP || (ph == PH_CMAGIC && cnt == 0)))
                emit(mfep_pkg::EV_TRUNC, 0, 0, 0, 0, 0, 0, 0);
            clear_parser();
        end
        foreach (run_events[i]) begin
            r = run_events[i];
            r.last = (i == run_events.size() - 1);
            expected_events.push_back(r);
        end
    endtask

    initial begin
        o_errors = 0;
        o_pending = 0;
        clear_parser();
    end

    // Predict on every accepted byte, compare every accepted result.
    always @(posedge i_clk) begin
        mfep_pkg::t_result got;
        mfep_pkg::t_result want;
        if (!i_rst_n) begin
            clear_parser();
            expected_events.delete();
        end else begin
            if (i_valid && i_in_ready) parse_byte(i_file_byte, i_file_last);
            if (i_out_valid && i_ready) begin
                got = '{i_event_kind, i_main_value, i_aux_value, i_ticks_per_quarter,
                        i_channel, i_note_number, i_velocity, i_tone_hz, i_last_of_run};
                if (expected_events.size() == 0) begin
                    $display("%0t: unexpected event kind=%0d main=%0h", $time,
                             got.kind, got.main_value);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_events.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected kind=%0d main=%0h aux=%0h tpq=%0d",
                                 $time, want.kind, want.main_value, want.aux_value, want.tpq);
                        $display("    ch=%0d note=%0d vel=%0d tone=%0d last=%0b", want.channel,
                                 want.note, want.velocity, want.tone, want.last);
                        $display("  actual kind=%0d main=%0h aux=%0h tpq=%0d", got.kind,
                                 got.main_value, got.aux_value, got.tpq);
                        $display("    ch=%0d note=%0d vel=%0d tone=%0d last=%0b", got.channel,
                                 got.note, got.velocity, got.tone, got.last);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
        o_pending <= expected_events.size();
    end

endmodule

// ----- test/tb_midi_file_event_parser_top.sv -----
// Testbench top for the MIDI file event parser: builds MIDI files byte by byte,
// drives them with random gaps and gives the verdict. Depends on mfep_event_checker.
`timescale 1ns / 1ps
module tb_midi_file_event_parser_top;

    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_file_byte = '0;
    logic        i_file_last = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [3:0]  o_event_kind;
    logic [51:0] o_main_value;
    logic [15:0] o_aux_value;
    logic [15:0] o_ticks_per_quarter;
    logic [3:0]  o_channel;
    logic [6:0]  o_note_number;
    logic [6:0]  o_velocity;
    logic [13:0] o_tone_hz;
    logic        o_last_of_run;
    int          errors;
    int          pending;
    int          bytes_sent = 0;
    int          events_seen = 0;
    int          idle_cycles = 0;
    logic [7:0]  file_q[$];
    logic [7:0]  body_q[$];

    always #2 i_clk = ~i_clk;

    midi_file_event_parser_top u_top (.*);

    mfep_event_checker u_chk (
        .i_clk, .i_rst_n, .i_valid, .i_in_ready(o_ready), .i_file_byte, .i_file_last,
        .i_out_valid(o_valid), .i_ready, .i_event_kind(o_event_kind),
        .i_main_value(o_main_value), .i_aux_value(o_aux_value),
        .i_ticks_per_quarter(o_ticks_per_quarter), .i_channel(o_channel),
        .i_note_number(o_note_number), .i_velocity(o_velocity), .i_tone_hz(o_tone_hz),
        .i_last_of_run(o_last_of_run), .o_errors(errors), .o_pending(pending)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        return ($urandom_range(9) == 0) ? $urandom_range(60, 10) : $urandom_range(3, 1);
    endfunction

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (o_valid && i_ready) events_seen <= events_seen + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: random stalls, calm stretches and one long hold-off.
    initial begin
        bit held;
        bit calm;
        held = 0;
        calm = 0;
        forever begin
            @(posedge i_clk);
            if ($urandom_range(199) == 0) calm = !calm;
            if (i_rst_n && !held && events_seen >= 200) begin
                held = 1;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_ready <= 1'b1;
            end else if (!calm && $urandom_range(3) == 0) begin
                i_ready <= 1'b0;
                repeat (gap_len()) @(posedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic put_word(input logic [31:0] w, input int nb);
        for (int i = nb - 1; i >= 0; i--) file_q.push_back(w[8 * i +: 8]);
    endtask

    // Variable-length value of nb bytes; a four-byte one may keep its top bit set.
    task automatic put_varlen(input logic [27:0] v, input int nb);
        for (int i = nb - 1; i >= 0; i--)
            body_q.push_back({(i != 0) || (nb == 4 && $urandom_range(3) == 0), v[7 * i +: 7]});
    endtask

    task automatic put_header(input logic [15:0] div);
        put_word(32'h4D546864, 4);
        put_word(($urandom_range(3) == 0) ? $urandom : 32'd6, 4);
        put_word($urandom, 4);
        put_word(div, 2);
    endtask

    task automatic put_meta(input logic [7:0] mt, input int len);
        body_q.push_back(8'hFF);
        body_q.push_back(mt);
        put_varlen(len, (len > 127) ? 2 : 1);
        repeat (len) body_q.push_back($urandom_range(255));
    endtask

    task automatic add_event();
        int sel;
        int nb;
        logic [7:0] mt;
        sel = $urandom_range(99);
        nb = $urandom_range(4, 1);
        put_varlen(($urandom_range(4) == 0) ? '0 : 28'($urandom), nb);
        if (sel < 40) begin
            body_q.push_back({$urandom_range(1) ? 4'h9 : 4'h8, 4'($urandom)});
            body_q.push_back($urandom_range(255));
            body_q.push_back(($urandom_range(5) == 0) ? 8'h00 : 8'($urandom));
        end else if (sel < 52) begin
            body_q.push_back({($urandom_range(2) == 0) ? 4'hA : ($urandom_range(1) ? 4'hB : 4'hE),
                              4'($urandom)});
            body_q.push_back($urandom_range(255));
            body_q.push_back($urandom_range(255));
        end else if (sel < 60) begin
            body_q.push_back({$urandom_range(1) ? 4'hC : 4'hD, 4'($urandom)});
            body_q.push_back($urandom_range(255));
        end else if (sel < 75) begin
            put_meta(8'h51, ($urandom_range(3) == 0) ? $urandom_range(6) : 3);
        end else if (sel < 90) begin
            case ($urandom_range(5))
                0: mt = $urandom_range(9);
                1: mt = 8'h20 + $urandom_range(1);
                2: mt = 8'h58 + $urandom_range(1);
                3: mt = 8'h54;
                4: mt = 8'h7F;
                default: mt = 8'h2F;
            endcase
            put_meta(mt, ($urandom_range(15) == 0) ? 130 : $urandom_range(6));
        end else if (sel < 95) begin
            put_meta(8'h0A + $urandom_range(8'h15), $urandom_range(4));
        end else begin
            body_q.push_back($urandom_range(1) ? 8'($urandom_range(8'hFE, 8'hF0))
                                              : 8'($urandom_range(8'h7F)));
        end
    endtask

    // Track chunk; its size is sometimes wrong so that events get cut.
    task automatic put_track(input int n_events);
        int size;
        body_q.delete();
        repeat (n_events) add_event();
        size = body_q.size();
        if ($urandom_range(9) == 0) size = $urandom_range(size);
        put_word(32'h4D54726B, 4);
        put_word(size, 4);
        foreach (body_q[i]) file_q.push_back(body_q[i]);
    endtask

    // Sends the whole file, raising the last flag on its final byte.
    task automatic send_file();
        int n;
        n = file_q.size();
        for (int i = 0; i < n; i++) begin
            i_file_byte <= file_q[i];
            i_file_last <= (i == n - 1);
            i_valid <= 1'b1;
            do @(posedge i_clk); while (!o_ready);
            bytes_sent++;
            if ($urandom_range(3) == 0) begin
                i_valid <= 1'b0;
                repeat (gap_len()) @(posedge i_clk);
            end
        end
        file_q.delete();
    endtask

    initial begin
        int kind;
        int cut;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Broken magic, then zero division.
        put_word(32'h4D54FF64, 4);
        send_file();
        put_header(16'h0000);
        send_file();
        // Deepest delta, extreme notes, a short tempo meta, a data byte as status.
        put_header(16'hFFFF);
        body_q.delete();
        put_varlen(28'hFFFFFFF, 4);
        body_q.push_back(8'h9F); body_q.push_back(8'h7F); body_q.push_back(8'h7F);
        body_q.push_back(8'h00);
        body_q.push_back(8'h90); body_q.push_back(8'h00); body_q.push_back(8'h00);
        body_q.push_back(8'h00);
        put_meta(8'h51, 2);
        body_q.push_back(8'h00);
        body_q.push_back(8'h40);
        put_word(32'h4D54726B, 4);
        put_word(body_q.size(), 4);
        foreach (body_q[i]) file_q.push_back(body_q[i]);
        put_track(0);
        put_word(32'h4D54FFFF, 2);
        send_file();

        // Random files: mostly well formed, some cut short, some noise.
        while (bytes_sent < 1100) begin
            kind = $urandom_range(9);
            if (kind == 0) begin
                repeat ($urandom_range(20, 1)) file_q.push_back($urandom_range(255));
            end else begin
                case ($urandom_range(7))
                    0: put_header(16'd1);
                    1: put_header(16'hFFFF);
                    2: put_header(($urandom_range(3) == 0) ? 16'd0 : 16'($urandom));
                    default: put_header($urandom_range(960, 24));
                endcase
                repeat ($urandom_range(3)) put_track($urandom_range(10));
                if ($urandom_range(9) == 0) put_word(32'h4D546864, 4);
                if (kind == 1 && file_q.size() > 1) begin
                    cut = $urandom_range(file_q.size() - 1, 1);
                    while (file_q.size() > cut) void'(file_q.pop_back());
                end
            end
            send_file();
        end
        i_valid <= 1'b0;
        i_file_last <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- midi_file_event_parser_top.f -----
rtl/core/mfep_pkg.sv
rtl/core/mfep_queue.sv
rtl/core/mfep_divider.sv
rtl/core/mfep_front.sv
rtl/core/midi_file_event_parser_top.sv
test/mfep_event_checker.sv
test/tb_midi_file_event_parser_top.sv
